// ===== src/assert_macros.svh =====
// Assertion macros shared by the RTL of the radix digit printer.
// No dependencies; synthesis builds see empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled while reset is held low
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held low
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

// ===== src/itrd_pkg.sv =====
// Package for the radix digit printer: widths, radix codes, reciprocal
// constant, control struct and the digit-to-ASCII function. No dependencies.
`default_nettype none

package itrd_pkg;

    localparam int VALUE_WIDTH = 32;
    localparam int CNT_W       = $clog2(VALUE_WIDTH + 1);
    localparam int DIGIT_W     = 4;
    localparam int SYM_W       = 8;
    localparam int RADIX_W     = 3;

    // Decimal split: quotient = (mag * DEC_RECIP) >> DEC_SHIFT
    localparam int PROD_W    = 2 * VALUE_WIDTH;
    localparam int DEC_SHIFT = VALUE_WIDTH + 3;
    localparam logic [PROD_W-1:0] DEC_RECIP_WIDE =
        ((PROD_W)'(1) << DEC_SHIFT) / 10 + (PROD_W)'(1);
    localparam logic [VALUE_WIDTH-1:0] DEC_RECIP = DEC_RECIP_WIDE[VALUE_WIDTH-1:0];

    // Radix register codes; codes above RADIX_HEX are unrecognized
    localparam logic [RADIX_W-1:0] RADIX_BIN = 3'd0;
    localparam logic [RADIX_W-1:0] RADIX_OCT = 3'd1;
    localparam logic [RADIX_W-1:0] RADIX_DEC = 3'd2;
    localparam logic [RADIX_W-1:0] RADIX_HEX = 3'd3;

    localparam logic [SYM_W-1:0] ASCII_MINUS  = 8'h2D;
    localparam logic [SYM_W-1:0] ASCII_ZERO   = 8'h30;
    localparam logic [SYM_W-1:0] ASCII_UPPERA = 8'h41;

    // Control from the sequencer to the digit unit
    typedef struct packed {
        logic                 mul_en;
        logic [RADIX_W-1:0]   radix;
    } ctl_t;

    // Map a digit value to its uppercase ASCII symbol
    function automatic logic [SYM_W-1:0] digit_ascii(input logic [DIGIT_W-1:0] d);
        logic [SYM_W-1:0] ext;
        ext = {{(SYM_W-DIGIT_W){1'b0}}, d};
        if (d < 4'd10) begin
            return ASCII_ZERO + ext;
        end else begin
            return ASCII_UPPERA + ext - 8'd10;
        end
    endfunction

endpackage

`default_nettype wire

// ===== src/itrd_digit_unit.sv =====
// Shared digit unit: splits a magnitude into quotient and low digit for the
// selected radix. Depends on itrd_pkg.
`default_nettype none

module itrd_digit_unit (
    input  wire logic                              aclk,
    input  wire itrd_pkg::ctl_t                    ctl,
    input  wire logic [itrd_pkg::VALUE_WIDTH-1:0]  mag_i,
    output logic      [itrd_pkg::VALUE_WIDTH-1:0]  quot_o,
    output logic      [itrd_pkg::DIGIT_W-1:0]      rem_o
);

    logic [itrd_pkg::PROD_W-1:0]      prod_reg;
    logic [itrd_pkg::VALUE_WIDTH-1:0] dec_quot;
    logic [itrd_pkg::VALUE_WIDTH-1:0] dec_diff;

    // Capture the reciprocal product; mag_i holds until the split cycle
    always_ff @(posedge aclk) begin
        if (ctl.mul_en) begin
            prod_reg <= itrd_pkg::PROD_W'(mag_i) * itrd_pkg::PROD_W'(itrd_pkg::DEC_RECIP);
        end
    end

    // Decimal quotient and remainder from the registered product
    assign dec_quot = itrd_pkg::VALUE_WIDTH'(prod_reg >> itrd_pkg::DEC_SHIFT);
    assign dec_diff = mag_i - ((dec_quot << 3) + (dec_quot << 1));

    // Select the split for the radix
    always_comb begin
        case (ctl.radix)
            itrd_pkg::RADIX_BIN: begin
                quot_o = mag_i >> 1;
                rem_o  = {3'b000, mag_i[0]};
            end
            itrd_pkg::RADIX_OCT: begin
                quot_o = mag_i >> 3;
                rem_o  = {1'b0, mag_i[2:0]};
            end
            itrd_pkg::RADIX_DEC: begin
                quot_o = dec_quot;
                rem_o  = dec_diff[itrd_pkg::DIGIT_W-1:0];
            end
            itrd_pkg::RADIX_HEX: begin
                quot_o = mag_i >> 4;
                rem_o  = mag_i[3:0];
            end
            default: begin
                quot_o = '0;
                rem_o  = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== src/integer_to_radix_digits.sv =====
// Radix digit printer top level: sequencer, digit stack and output register.
// Depends on itrd_pkg, itrd_digit_unit and assert_macros.svh.
//
// Takes one signed 32-bit number per input transfer and sends its ASCII
// characters, most significant first, one per output transfer, with tlast on
// the final one: '-' first for negatives, then the digits of the magnitude in
// binary, octal, decimal or uppercase hex per the radix register (reset:
// decimal). Zero prints "0"; an unrecognized radix code drops the number. The
// shared digit unit yields one digit per cycle for the power-of-two radices
// and in decimal alternates a registered 32x32 reciprocal multiply in ST_MUL
// with the split in ST_SPLIT; digits collect on a stack and then drain one
// per cycle while the sink is ready. s_tready is low until the last
// character is loaded.
`default_nettype none
`include "assert_macros.svh"

module integer_to_radix_digits (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // radix register write
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [itrd_pkg::RADIX_W-1:0]      cfg_data,     // radix_select
    // number in
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [itrd_pkg::VALUE_WIDTH-1:0]  s_tdata,      // value
    // characters out
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic      [itrd_pkg::SYM_W-1:0]        m_tdata,      // symbol
    output logic                                   m_tlast       // last_char
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_SPLIT,
        ST_SIGN,
        ST_EMIT
    } state_t;

    state_t                            state_reg;
    logic [itrd_pkg::RADIX_W-1:0]      radix_reg;
    logic [itrd_pkg::VALUE_WIDTH-1:0]  mag_reg;
    logic                              neg_reg;
    logic [itrd_pkg::CNT_W-1:0]        count_reg;
    logic [itrd_pkg::DIGIT_W-1:0]      stack_reg [itrd_pkg::VALUE_WIDTH];
    logic                              m_tvalid_reg;
    logic [itrd_pkg::SYM_W-1:0]        m_tdata_reg;
    logic                              m_tlast_reg;

    itrd_pkg::ctl_t                    unit_ctl;
    logic [itrd_pkg::VALUE_WIDTH-1:0]  unit_quot;
    logic [itrd_pkg::DIGIT_W-1:0]      unit_rem;
    logic [itrd_pkg::VALUE_WIDTH-1:0]  in_mag;
    logic                              radix_known;
    logic                              is_dec;
    logic                              out_free;
    logic                              out_load;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE);
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign m_tlast   = m_tlast_reg;

    assign radix_known = (radix_reg == itrd_pkg::RADIX_BIN) || (radix_reg == itrd_pkg::RADIX_OCT)
                      || (radix_reg == itrd_pkg::RADIX_DEC) || (radix_reg == itrd_pkg::RADIX_HEX);
    assign is_dec      = (radix_reg == itrd_pkg::RADIX_DEC);
    assign out_free    = !m_tvalid_reg || m_tready;

    // Load the output register from the sign and digit states
    assign out_load    = out_free && ((state_reg == ST_SIGN) || (state_reg == ST_EMIT));

    // Magnitude of the incoming number; the most negative value maps to 2^(W-1)
    assign in_mag = s_tdata[itrd_pkg::VALUE_WIDTH-1] ? (~s_tdata + 1'b1) : s_tdata;

    assign unit_ctl.mul_en = (state_reg == ST_MUL);
    assign unit_ctl.radix  = radix_reg;

    itrd_digit_unit u_digit (
        .aclk   (aclk),
        .ctl    (unit_ctl),
        .mag_i  (mag_reg),
        .quot_o (unit_quot),
        .rem_o  (unit_rem)
    );

    // Sequencer, digit stack and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            radix_reg    <= itrd_pkg::RADIX_DEC;
            neg_reg      <= 1'b0;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                radix_reg <= cfg_data;
            end
            // raise the valid on a load, drop it once the character is taken
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid && radix_known) begin
                        mag_reg   <= in_mag;
                        neg_reg   <= s_tdata[itrd_pkg::VALUE_WIDTH-1];
                        count_reg <= '0;
                        state_reg <= is_dec ? ST_MUL : ST_SPLIT;
                    end
                end
                ST_MUL: begin
                    state_reg <= ST_SPLIT;
                end
                ST_SPLIT: begin
                    // push the low digit and advance to the quotient
                    stack_reg[0] <= unit_rem;
                    for (int i = 1; i < itrd_pkg::VALUE_WIDTH; i++) begin
                        stack_reg[i] <= stack_reg[i-1];
                    end
                    count_reg <= count_reg + 1'b1;
                    mag_reg   <= unit_quot;
                    if (unit_quot == '0) begin
                        state_reg <= neg_reg ? ST_SIGN : ST_EMIT;
                    end else begin
                        state_reg <= is_dec ? ST_MUL : ST_SPLIT;
                    end
                end
                ST_SIGN: begin
                    if (out_free) begin
                        m_tdata_reg  <= itrd_pkg::ASCII_MINUS;
                        m_tlast_reg  <= 1'b0;
                        state_reg    <= ST_EMIT;
                    end
                end
                ST_EMIT: begin
                    // pop the most significant digit into the output register
                    if (out_free) begin
                        m_tdata_reg  <= itrd_pkg::digit_ascii(stack_reg[0]);
                        m_tlast_reg  <= (count_reg == itrd_pkg::CNT_W'(1));
                        for (int i = 0; i < itrd_pkg::VALUE_WIDTH - 1; i++) begin
                            stack_reg[i] <= stack_reg[i+1];
                        end
                        count_reg <= count_reg - 1'b1;
                        if (count_reg == itrd_pkg::CNT_W'(1)) begin
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    `ASSERT_IMPLIES(a_idle_stack_empty, aclk, aresetn, state_reg == ST_IDLE, count_reg == '0, "digit stack not empty while idle")
    `ASSERT_IMPLIES(a_stack_bound, aclk, aresetn, 1'b1, count_reg <= itrd_pkg::CNT_W'(itrd_pkg::VALUE_WIDTH), "digit stack overflow")
    `ASSERT_IMPLIES(a_dec_digit, aclk, aresetn, state_reg == ST_SPLIT && is_dec, unit_rem < 4'd10, "decimal digit out of range")
    `ASSERT_NEXT(a_last_marked, aclk, aresetn, state_reg == ST_EMIT && out_free && count_reg == itrd_pkg::CNT_W'(1), m_tvalid && m_tlast, "final character not marked last")
    `ASSERT_NEXT(a_emit_nonempty, aclk, aresetn, state_reg == ST_SPLIT, count_reg != '0, "split left the digit stack empty")

endmodule

`default_nettype wire
